/* design/izh_pkg.sv */
// ---------------------------------------------------------------------------
// izh_pkg: shared types, constants and helpers of the neuron update core
// Field widths, register indexes, fixed-point constants and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package izh_pkg;

    // field widths
    localparam int IDX_W = 10;
    localparam int CUR_W = 24;
    localparam int V_W   = 32;
    localparam int AB_W  = 16;
    localparam int CD_W  = 24;
    localparam int CNT_W = 11;
    localparam int CFG_IDX_W = 3;

    // stages in one Euler substep cell
    localparam int CELL_STAGES = 8;

    // defaults
    localparam int MAX_NEURONS_DEF = 1024;
    localparam int SUBSTEPS_DEF    = 4;

    localparam logic [AB_W-1:0]  A_RESET   = 16'd6554;
    localparam logic [AB_W-1:0]  B_RESET   = 16'd13107;
    localparam logic [CD_W-1:0]  C_RESET   = 24'hBF0000;   // -65.0
    localparam logic [CD_W-1:0]  D_RESET   = 24'h020000;   // 2.0
    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A     = 3'd0,
        CFG_B     = 3'd1,
        CFG_C     = 3'd2,
        CFG_D     = 3'd3,
        CFG_COUNT = 3'd4
    } cfg_idx_e;

    // Q16.16 constants
    localparam logic signed [63:0] K_004 = 64'sd2621;
    localparam logic signed [67:0] K_5   = 68'sd327680;
    localparam logic signed [67:0] K_140 = 68'sd9175040;
    localparam logic signed [31:0] K_30  = 32'sd1966080;

    // control travelling with each item
    typedef struct packed {
        logic             valid;
        logic             init;
        logic             err;
        logic             fired;
        logic [IDX_W-1:0] idx;
    } cell_ctl_t;

    // item with its neuron state
    typedef struct packed {
        cell_ctl_t        ctl;
        logic [V_W-1:0]   v;
        logic [V_W-1:0]   u;
        logic [CUR_W-1:0] cur;
    } neuron_st_t;

    // saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > 68'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (x < -68'sd2147483648)
            return 32'sh80000000;
        else
            return $signed(x[31:0]);
    endfunction

    // Q16.16 product back to Q16.16, rounding toward minus infinity
    function automatic logic signed [67:0] fl16(input logic signed [63:0] m);
        return 68'(m >>> 16);
    endfunction

    // item still evolving in the substep chain
    function automatic logic is_active(input cell_ctl_t c);
        return c.valid & ~c.init & ~c.err & ~c.fired;
    endfunction

endpackage

`default_nettype wire

/* design/izh_ram.sv */
// ---------------------------------------------------------------------------
// izh_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module izh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/izh_cell.sv */
// ---------------------------------------------------------------------------
// izh_cell: one Euler substep of the neuron equations
// Eight register stages; items already fired, init or error pass unchanged.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module izh_cell #(
    parameter int SUBSTEPS = izh_pkg::SUBSTEPS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic [izh_pkg::AB_W-1:0]             a_cfg,
    input  wire logic [izh_pkg::AB_W-1:0]             b_cfg,
    input  wire izh_pkg::neuron_st_t                  st_in,
    output izh_pkg::neuron_st_t                       st_out,
    output izh_pkg::cell_ctl_t [izh_pkg::CELL_STAGES-1:0] taps
);

    // floor division by SUBSTEPS: offset to positive, reciprocal, one correction
    localparam int SH = 34;
    localparam logic [63:0] OFFQ64 =
        (64'd2147483648 + 64'(SUBSTEPS) - 64'd1) / 64'(SUBSTEPS);
    localparam logic [35:0] OFFQ  = 36'(OFFQ64);
    localparam logic [35:0] OFF   = 36'(OFFQ64 * 64'(SUBSTEPS));
    localparam logic [34:0] RECIP = 35'((64'd1 << SH) / 64'(SUBSTEPS));
    localparam logic [36:0] DV    = 37'(SUBSTEPS);

    function automatic logic [65:0] div_first(input logic signed [31:0] t);
        logic [32:0] xn;
        logic [67:0] p;
        xn = 33'(36'(t) + OFF);
        p  = 68'(xn) * 68'(RECIP);
        return {xn, p[SH+32:SH]};
    endfunction

    function automatic logic signed [34:0] div_fin(input logic [32:0] xn,
                                                   input logic [32:0] q0);
        logic [36:0] r;
        logic [33:0] q;
        r = 37'(xn) - 37'(q0) * DV;
        q = 34'(q0) + 34'(r >= DV);
        return $signed(35'(q)) - $signed(35'(OFFQ));
    endfunction

    izh_pkg::neuron_st_t st_reg [izh_pkg::CELL_STAGES];
    izh_pkg::neuron_st_t st3_next, st7_next;

    logic signed [63:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic [32:0]        xv_reg, qv_reg, xu_reg, qu_reg;

    logic signed [16:0] a_s, b_s;
    logic signed [31:0] t2, t4, bv, t5, x2, vn, un;
    logic signed [34:0] fv, fu;
    logic [65:0]        dv_first, du_first;
    logic               fire_now;

    assign a_s = $signed({1'b0, a_cfg});
    assign b_s = $signed({1'b0, b_cfg});

    // per-stage arithmetic
    always_comb
    begin
        t2 = izh_pkg::sat32(68'(izh_pkg::sat32(izh_pkg::fl16(m1_reg))) + izh_pkg::K_5);
        t4 = izh_pkg::sat32(68'(izh_pkg::sat32(izh_pkg::fl16(m2_reg)))
                            + izh_pkg::K_140
                            - 68'($signed(st_reg[1].u))
                            + 68'($signed(st_reg[1].cur)));
        dv_first = div_first(t4);
        fv = div_fin(xv_reg, qv_reg);
        vn = izh_pkg::sat32(68'($signed(st_reg[2].v)) + 68'(fv));
        bv = izh_pkg::sat32(izh_pkg::fl16(m3_reg));
        t5 = izh_pkg::sat32(68'(bv) - 68'($signed(st_reg[4].u)));
        x2 = izh_pkg::sat32(izh_pkg::fl16(m4_reg));
        du_first = div_first(x2);
        fu = div_fin(xu_reg, qu_reg);
        un = izh_pkg::sat32(68'($signed(st_reg[6].u)) + 68'(fu));
        fire_now = izh_pkg::is_active(st_reg[6].ctl) && ($signed(st_reg[6].v) >= izh_pkg::K_30);
    end

    // items leaving the new-v and new-u stages
    always_comb
    begin
        st3_next = st_reg[2];
        if (izh_pkg::is_active(st_reg[2].ctl))
            st3_next.v = vn;
        st7_next = st_reg[6];
        if (izh_pkg::is_active(st_reg[6].ctl))
            st7_next.u = un;
        st7_next.ctl.fired = st_reg[6].ctl.fired | fire_now;
    end

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < izh_pkg::CELL_STAGES; k++)
                st_reg[k].ctl.valid <= 1'b0;
        end
        else if (en)
        begin
            // 0.04 v
            st_reg[0] <= st_in;
            m1_reg    <= 64'($signed(st_in.v)) * izh_pkg::K_004;
            // (0.04 v + 5) v
            st_reg[1] <= st_reg[0];
            m2_reg    <= 64'(t2) * 64'($signed(st_reg[0].v));
            // sum, first half of the step division
            st_reg[2] <= st_reg[1];
            xv_reg    <= dv_first[65:33];
            qv_reg    <= dv_first[32:0];
            // new v
            st_reg[3] <= st3_next;
            // b v
            st_reg[4] <= st_reg[3];
            m3_reg    <= 64'($signed(st_reg[3].v)) * 64'(b_s);
            // a (b v - u)
            st_reg[5] <= st_reg[4];
            m4_reg    <= 64'(t5) * 64'(a_s);
            // first half of the step division for u
            st_reg[6] <= st_reg[5];
            xu_reg    <= du_first[65:33];
            qu_reg    <= du_first[32:0];
            // new u and spike test
            st_reg[7] <= st7_next;
        end
    end

    assign st_out = st_reg[izh_pkg::CELL_STAGES-1];

    always_comb
    begin
        for (int k = 0; k < izh_pkg::CELL_STAGES; k++)
            taps[k] = st_reg[k].ctl;
    end

endmodule

`default_nettype wire

/* design/izhikevich_neuron_update_core.sv */
// ---------------------------------------------------------------------------
// izhikevich_neuron_update_core: Izhikevich neuron bank, fixed-point Euler
// Per-neuron v/u in RAM, a chain of substep cells, writeback and output.
// ---------------------------------------------------------------------------
// The core takes one transaction per clock, unless held on s_tready, and
// returns one result per transaction, in order. A transaction passes the
// RAM read stage, eight pipeline stages in each substep cell (one per
// multiplier and per half of the step division), then the output
// register. A transaction whose neuron still has an update in flight is
// held on s_tready until that update is written back; back-to-back
// transactions on distinct neurons run at one per cycle while m_tready
// does not stall the output. Both state RAMs are undefined after reset;
// a neuron must be initialised before its first update.
`timescale 1ns / 1ps
`default_nettype none

module izhikevich_neuron_update_core #(
    parameter int MAX_NEURONS = izh_pkg::MAX_NEURONS_DEF,
    parameter int SUBSTEPS    = izh_pkg::SUBSTEPS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [izh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [izh_pkg::CD_W-1:0]       cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [9:0] neuron_index, [33:10] input_current
    input  wire logic        s_tuser,   // [0] req_type
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [9:0] out_neuron, [41:10] membrane_v
    output logic [1:0]       m_tuser    // [0] fired, [1] index_error
);

    localparam int AW    = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int NS    = izh_pkg::CELL_STAGES;
    localparam int NTAPS = 1 + NS * SUBSTEPS;

    // configuration registers
    logic [izh_pkg::AB_W-1:0]  a_reg, b_reg;
    logic [izh_pkg::CD_W-1:0]  c_reg, d_reg;
    logic [izh_pkg::CNT_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= izh_pkg::A_RESET;
            b_reg   <= izh_pkg::B_RESET;
            c_reg   <= izh_pkg::C_RESET;
            d_reg   <= izh_pkg::D_RESET;
            cnt_reg <= izh_pkg::CNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                izh_pkg::CFG_A:     a_reg   <= cfg_data[izh_pkg::AB_W-1:0];
                izh_pkg::CFG_B:     b_reg   <= cfg_data[izh_pkg::AB_W-1:0];
                izh_pkg::CFG_C:     c_reg   <= cfg_data;
                izh_pkg::CFG_D:     d_reg   <= cfg_data;
                izh_pkg::CFG_COUNT: cnt_reg <= cfg_data[izh_pkg::CNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // input fields
    logic [izh_pkg::IDX_W-1:0] in_idx;
    logic [izh_pkg::CUR_W-1:0] in_cur;
    logic                      in_err;

    assign in_idx = s_tdata[9:0];
    assign in_cur = s_tdata[33:10];
    assign in_err = (12'(in_idx) >= 12'(cnt_reg)) || (32'(in_idx) >= 32'(MAX_NEURONS));

    // pipeline advance and in-flight hazard
    logic                 en, hazard, accept;
    izh_pkg::cell_ctl_t   taps [NTAPS];

    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < NTAPS; k++)
            if (taps[k].valid && !taps[k].err && (taps[k].idx == in_idx))
                hazard = 1'b1;
    end

    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en && !hazard;
    assign accept   = s_tvalid && s_tready;

    // read stage
    izh_pkg::cell_ctl_t        st0_ctl_reg;
    logic [izh_pkg::CUR_W-1:0] st0_cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st0_ctl_reg.valid <= 1'b0;
        else if (en)
        begin
            st0_ctl_reg.valid <= accept;
            st0_ctl_reg.init  <= s_tuser;
            st0_ctl_reg.err   <= in_err;
            st0_ctl_reg.fired <= 1'b0;
            st0_ctl_reg.idx   <= in_idx;
            st0_cur_reg       <= in_cur;
        end
    end

    assign taps[0] = st0_ctl_reg;

    // state RAMs
    logic [izh_pkg::V_W-1:0] ram_v_q, ram_u_q, wb_v, wb_u;
    logic                    wb_we;
    izh_pkg::neuron_st_t     chain [SUBSTEPS+1];

    izh_ram #(.WIDTH(izh_pkg::V_W), .DEPTH(MAX_NEURONS)) u_v_ram (
        .clk   (clk),
        .we    (wb_we),
        .waddr (AW'(chain[SUBSTEPS].ctl.idx)),
        .wdata (wb_v),
        .re    (en),
        .raddr (AW'(in_idx)),
        .rdata (ram_v_q)
    );

    izh_ram #(.WIDTH(izh_pkg::V_W), .DEPTH(MAX_NEURONS)) u_u_ram (
        .clk   (clk),
        .we    (wb_we),
        .waddr (AW'(chain[SUBSTEPS].ctl.idx)),
        .wdata (wb_u),
        .re    (en),
        .raddr (AW'(in_idx)),
        .rdata (ram_u_q)
    );

    assign chain[0].ctl = st0_ctl_reg;
    assign chain[0].v   = ram_v_q;
    assign chain[0].u   = ram_u_q;
    assign chain[0].cur = st0_cur_reg;

    // substep cells
    for (genvar g = 0; g < SUBSTEPS; g++)
    begin : g_cell
        izh_pkg::cell_ctl_t [NS-1:0] cell_taps;

        izh_cell #(.SUBSTEPS(SUBSTEPS)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .a_cfg  (a_reg),
            .b_cfg  (b_reg),
            .st_in  (chain[g]),
            .st_out (chain[g+1]),
            .taps   (cell_taps)
        );

        for (genvar k = 0; k < NS; k++)
        begin : g_tap
            assign taps[1 + g*NS + k] = cell_taps[k];
        end
    end

    // writeback: init, spike reset or plain update
    izh_pkg::neuron_st_t last;
    logic signed [31:0]  c_s, d_s;
    logic signed [16:0]  b_s;

    assign last = chain[SUBSTEPS];
    assign c_s  = 32'($signed(c_reg));
    assign d_s  = 32'($signed(d_reg));
    assign b_s  = $signed({1'b0, b_reg});

    always_comb
    begin
        if (last.ctl.init)
        begin
            wb_v = c_s;
            wb_u = izh_pkg::sat32(izh_pkg::fl16(64'(b_s) * 64'(c_s)));
        end
        else if (last.ctl.fired)
        begin
            wb_v = c_s;
            wb_u = izh_pkg::sat32(68'($signed(last.u)) + 68'(d_s));
        end
        else
        begin
            wb_v = last.v;
            wb_u = last.u;
        end
    end

    assign wb_we = en && last.ctl.valid && !last.ctl.err;

    // output register
    logic [izh_pkg::IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [izh_pkg::V_W-1:0]   out_v_reg, out_v_next;
    logic                      out_fired_reg, out_fired_next;
    logic                      out_err_reg, out_err_next;

    always_comb
    begin
        out_idx_next   = last.ctl.idx;
        out_err_next   = last.ctl.err;
        out_fired_next = last.ctl.fired && !last.ctl.err && !last.ctl.init;
        out_v_next     = last.ctl.err ? '0 : wb_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
        begin
            out_valid_reg <= last.ctl.valid;
            out_idx_reg   <= out_idx_next;
            out_v_reg     <= out_v_next;
            out_fired_reg <= out_fired_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_v_reg, out_idx_reg};
    assign m_tuser  = {out_err_reg, out_fired_reg};

    // checks
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata[41:10] == '0))
        else $error("error result carries state");

    a_fire_reset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[41:10] == c_s))
        else $error("fired result without reset voltage");

    a_wb_out: assert property (@(posedge clk) disable iff (!rst_n)
        wb_we |=> out_valid_reg)
        else $error("writeback without result");

endmodule

`default_nettype wire
